FILE: rtl/tfc_pkg.sv
// Package of the trajectory feasibility checker: shared types, codes and constants.
// Holds the command and status structs between controller and datapath and the
// multiplier schedule. Depends on nothing.
package tfc_pkg;

   // The shared multiplier works on 33-bit limbs; wide products build up in an
   // accumulator of eight limbs.
   localparam int LIMB_W    = 33;
   localparam int PAIR_W    = 2 * LIMB_W;
   localparam int QUAD_W    = 4 * LIMB_W;
   localparam int SIX_W     = 6 * LIMB_W;
   localparam int ACC_LIMBS = 8;
   localparam int ACC_W     = ACC_LIMBS * LIMB_W;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPEED_LIMIT     = 3'd0,
      CSR_CURVATURE_LIMIT = 3'd1,
      CSR_TUBE_MARGIN     = 3'd2,
      CSR_X_LOWER_BOUND   = 3'd3,
      CSR_X_UPPER_BOUND   = 3'd4,
      CSR_Y_LOWER_BOUND   = 3'd5,
      CSR_Y_UPPER_BOUND   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [30:0]        speed_limit;
      logic [30:0]        curvature_limit;
      logic [30:0]        tube_margin;
      logic signed [31:0] x_lower_bound;
      logic signed [31:0] x_upper_bound;
      logic signed [31:0] y_lower_bound;
      logic signed [31:0] y_upper_bound;
   } cfg_type;

   typedef enum logic [1:0] {
      VIOL_NONE  = 2'd0,
      VIOL_SPEED = 2'd1,
      VIOL_BEND  = 2'd2,
      VIOL_BOUND = 2'd3
   } viol_type;

   // Operand sources of the shared multiplier.
   typedef enum logic [3:0] {
      SRC_VX, SRC_VY, SRC_SL, SRC_DX, SRC_DY, SRC_DDX, SRC_DDY,
      SRC_K, SRC_S, SRC_N, SRC_SQ, SRC_CUBE, SRC_KSQ
   } src_type;

   // What happens to the accumulator once a product is complete.
   typedef enum logic [3:0] {
      DST_NONE, DST_VSUM, DST_SPEED, DST_S, DST_P1, DST_N,
      DST_LHS, DST_SQ, DST_CUBE, DST_KSQ, DST_BEND
   } dst_type;

   typedef enum logic [3:0] {
      PR_VX2, PR_VY2, PR_SL2, PR_X2, PR_Y2, PR_XDDY, PR_YDDX,
      PR_N2, PR_S2, PR_S3, PR_K2, PR_RHS
   } prod_type;

   typedef struct packed {
      src_type    a_src;
      src_type    b_src;
      logic [2:0] a_last;
      logic       b_last;
      logic       clear;
      dst_type    dst;
      prod_type   next;
   } prod_info_type;

   typedef struct packed {
      logic       capture;
      logic       prep;
      logic       mac_en;
      logic       mac_clear;
      src_type    a_src;
      src_type    b_src;
      logic [2:0] a_idx;
      logic       b_idx;
      dst_type    latch;
      logic       commit;
   } cmd_type;

   typedef struct packed {
      logic points_ge2;
      logic short_step;
      logic last_point;
      logic rsp_blocked;
   } status_type;

   // Product schedule: operand sources, limb counts, whether the accumulator
   // starts from zero, where the result goes and which product follows.
   function automatic prod_info_type prod_info(prod_type prod);
      prod_info_type info;
      info = '{SRC_VX, SRC_VX, 3'd0, 1'b0, 1'b1, DST_NONE, PR_VX2};
      unique case (prod)
         PR_VX2:  info = '{SRC_VX,   SRC_VX,  3'd0, 1'b0, 1'b1, DST_NONE,  PR_VY2};
         PR_VY2:  info = '{SRC_VY,   SRC_VY,  3'd0, 1'b0, 1'b0, DST_VSUM,  PR_SL2};
         PR_SL2:  info = '{SRC_SL,   SRC_SL,  3'd0, 1'b0, 1'b1, DST_SPEED, PR_X2};
         PR_X2:   info = '{SRC_DX,   SRC_DX,  3'd0, 1'b0, 1'b1, DST_NONE,  PR_Y2};
         PR_Y2:   info = '{SRC_DY,   SRC_DY,  3'd0, 1'b0, 1'b0, DST_S,     PR_XDDY};
         PR_XDDY: info = '{SRC_DX,   SRC_DDY, 3'd0, 1'b0, 1'b1, DST_P1,    PR_YDDX};
         PR_YDDX: info = '{SRC_DY,   SRC_DDX, 3'd0, 1'b0, 1'b1, DST_N,     PR_N2};
         PR_N2:   info = '{SRC_N,    SRC_N,   3'd1, 1'b1, 1'b1, DST_LHS,   PR_S2};
         PR_S2:   info = '{SRC_S,    SRC_S,   3'd1, 1'b1, 1'b1, DST_SQ,    PR_S3};
         PR_S3:   info = '{SRC_SQ,   SRC_S,   3'd3, 1'b1, 1'b1, DST_CUBE,  PR_K2};
         PR_K2:   info = '{SRC_K,    SRC_K,   3'd0, 1'b0, 1'b1, DST_KSQ,   PR_RHS};
         PR_RHS:  info = '{SRC_CUBE, SRC_KSQ, 3'd5, 1'b1, 1'b1, DST_BEND,  PR_VX2};
         default: ;
      endcase
      return info;
   endfunction

endpackage

FILE: rtl/tfc_csr.sv
// Configuration registers of the trajectory feasibility checker.
// Depends on tfc_pkg for the register index codes and the cfg_type struct.
module tfc_csr import tfc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   localparam logic [30:0] ONE     = 31'(64'd1 << FRAC_BITS);
   localparam logic [31:0] POS_TEN = 32'(64'd10 << FRAC_BITS);
   localparam logic [31:0] NEG_TEN = 32'(~POS_TEN + 32'd1);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_limit     <= ONE;
         cfg_ff.curvature_limit <= ONE;
         cfg_ff.tube_margin     <= '0;
         cfg_ff.x_lower_bound   <= NEG_TEN;
         cfg_ff.x_upper_bound   <= POS_TEN;
         cfg_ff.y_lower_bound   <= NEG_TEN;
         cfg_ff.y_upper_bound   <= POS_TEN;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SPEED_LIMIT:     cfg_ff.speed_limit     <= csr_wdata[30:0];
            CSR_CURVATURE_LIMIT: cfg_ff.curvature_limit <= csr_wdata[30:0];
            CSR_TUBE_MARGIN:     cfg_ff.tube_margin     <= csr_wdata[30:0];
            CSR_X_LOWER_BOUND:   cfg_ff.x_lower_bound   <= csr_wdata;
            CSR_X_UPPER_BOUND:   cfg_ff.x_upper_bound   <= csr_wdata;
            CSR_Y_LOWER_BOUND:   cfg_ff.y_lower_bound   <= csr_wdata;
            CSR_Y_UPPER_BOUND:   cfg_ff.y_upper_bound   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/tfc_ctrl.sv
// Controller of the trajectory feasibility checker: sequences capture, the
// multiplier schedule and the final commit. Depends on tfc_pkg.
module tfc_ctrl import tfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_MUL, ST_WB, ST_FINISH
   } state_type;

   state_type     state_ff, state_in;
   prod_type      prod_ff, prod_in;
   logic [2:0]    a_idx_ff, a_idx_in;
   logic          b_idx_ff, b_idx_in;
   prod_info_type info;

   assign info      = prod_info(prod_ff);
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      prod_in       = prod_ff;
      a_idx_in      = a_idx_ff;
      b_idx_in      = b_idx_ff;
      cmd           = '0;
      cmd.a_src     = info.a_src;
      cmd.b_src     = info.b_src;
      cmd.a_idx     = a_idx_ff;
      cmd.b_idx     = b_idx_ff;
      cmd.latch     = DST_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            prod_in  = PR_VX2;
            a_idx_in = '0;
            b_idx_in = 1'b0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mac_en    = 1'b1;
            cmd.mac_clear = info.clear && (a_idx_ff == 3'd0) && !b_idx_ff;
            if (b_idx_ff == info.b_last) begin
               b_idx_in = 1'b0;
               if (a_idx_ff == info.a_last) begin
                  a_idx_in = '0;
                  state_in = ST_WB;
               end else begin
                  a_idx_in = a_idx_ff + 3'd1;
               end
            end else begin
               b_idx_in = 1'b1;
            end
         end
         ST_WB: begin
            cmd.latch = info.dst;
            // The curvature part is skipped before the third point and on a
            // short step; the limit compare closes the schedule.
            if ((prod_ff == PR_SL2 && !status.points_ge2) ||
                (prod_ff == PR_YDDX && status.short_step) ||
                (prod_ff == PR_RHS)) begin
               state_in = ST_FINISH;
            end else begin
               prod_in  = info.next;
               state_in = ST_MUL;
            end
         end
         ST_FINISH: begin
            if (!(status.last_point && status.rsp_blocked)) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         prod_ff  <= PR_VX2;
         a_idx_ff <= '0;
         b_idx_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         prod_ff  <= prod_in;
         a_idx_ff <= a_idx_in;
         b_idx_ff <= b_idx_in;
      end
   end

endmodule

FILE: rtl/tfc_dpath.sv
// Datapath of the trajectory feasibility checker: point store, sticky flags,
// shared 33x33 multiply-accumulate, operand stores and the result register.
// Depends on tfc_pkg.
module tfc_dpath import tfc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic               req_final_point,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic               rsp_feasible,
   output logic [1:0]         rsp_violation
);

   // A step is short when 2500 * S <= 2^(2F); S is an integer, so this is S
   // at or below the floor of 2^(2F) / 2500.
   localparam logic [PAIR_W-1:0] SHORT_LIMIT = (PAIR_W'(1) << (2 * FRAC_BITS)) / PAIR_W'(2500);
   localparam int                LHS_SHIFT   = 4 * FRAC_BITS + 4;

   // Transaction payload
   logic [31:0] pos_x_ff, pos_y_ff;
   logic [31:0] vxm_ff, vym_ff;
   logic        last_ff;

   // Point store and sticky flags
   logic [31:0] older_x_ff, older_y_ff, newer_x_ff, newer_y_ff;
   logic [1:0]  points_ff;
   logic        speed_fault_ff, bend_fault_ff, bound_fault_ff;

   // Curvature operands
   logic [31:0] dxm_ff, dym_ff;
   logic [32:0] ddxm_ff, ddym_ff;
   logic        n_add_ff;

   // Accumulator and product stores
   logic [ACC_W-1:0]                acc_ff, acc_in;
   logic [PAIR_W-1:0]               vsum_ff, p1_ff;
   logic [1:0][LIMB_W-1:0]          s_ff, n_ff, ksq_ff;
   logic [3:0][LIMB_W-1:0]          lhs_ff, sq_ff;
   logic [5:0][LIMB_W-1:0]          cube_ff;

   // Result register
   logic        rsp_valid_ff;
   logic        feasible_ff;
   viol_type    violation_ff;

   // Differences for the curvature check and the tube bounds
   logic [32:0]        dx_s, dy_s;
   logic [33:0]        ddx_s, ddy_s;
   logic signed [33:0] px_w, py_w, margin_w;
   logic signed [33:0] x_lo_w, x_hi_w, y_lo_w, y_hi_w;
   logic               bound_hit;

   logic [LIMB_W-1:0]  a_limb, b_limb;
   logic [PAIR_W-1:0]  pp;
   logic [2:0]         pp_shift;
   logic [ACC_W-1:0]   pp_wide, lhs_wide;
   logic [PAIR_W-1:0]  acc_pair, p_sum, p_diff, n_in;
   logic [PAIR_W:0]    p_sum_w;
   viol_type           verdict;

   function automatic logic [LIMB_W-1:0] pick(src_type src, logic [2:0] idx);
      logic [LIMB_W-1:0] limb;
      unique case (src)
         SRC_VX:   limb = LIMB_W'(vxm_ff);
         SRC_VY:   limb = LIMB_W'(vym_ff);
         SRC_SL:   limb = LIMB_W'(cfg.speed_limit);
         SRC_DX:   limb = LIMB_W'(dxm_ff);
         SRC_DY:   limb = LIMB_W'(dym_ff);
         SRC_DDX:  limb = ddxm_ff;
         SRC_DDY:  limb = ddym_ff;
         SRC_K:    limb = LIMB_W'(cfg.curvature_limit);
         SRC_S:    limb = s_ff[idx[0]];
         SRC_N:    limb = n_ff[idx[0]];
         SRC_SQ:   limb = sq_ff[idx[1:0]];
         SRC_CUBE: limb = cube_ff[idx];
         SRC_KSQ:  limb = ksq_ff[idx[0]];
         default:  limb = '0;
      endcase
      return limb;
   endfunction

   assign dx_s  = {pos_x_ff[31], pos_x_ff} - {older_x_ff[31], older_x_ff};
   assign dy_s  = {pos_y_ff[31], pos_y_ff} - {older_y_ff[31], older_y_ff};
   assign ddx_s = {{2{pos_x_ff[31]}}, pos_x_ff} - {newer_x_ff[31], newer_x_ff, 1'b0}
                + {{2{older_x_ff[31]}}, older_x_ff};
   assign ddy_s = {{2{pos_y_ff[31]}}, pos_y_ff} - {newer_y_ff[31], newer_y_ff, 1'b0}
                + {{2{older_y_ff[31]}}, older_y_ff};

   assign px_w     = {{2{pos_x_ff[31]}}, pos_x_ff};
   assign py_w     = {{2{pos_y_ff[31]}}, pos_y_ff};
   assign margin_w = {3'b000, cfg.tube_margin};
   assign x_lo_w   = {{2{cfg.x_lower_bound[31]}}, cfg.x_lower_bound} + margin_w;
   assign x_hi_w   = {{2{cfg.x_upper_bound[31]}}, cfg.x_upper_bound} - margin_w;
   assign y_lo_w   = {{2{cfg.y_lower_bound[31]}}, cfg.y_lower_bound} + margin_w;
   assign y_hi_w   = {{2{cfg.y_upper_bound[31]}}, cfg.y_upper_bound} - margin_w;
   assign bound_hit = (px_w < x_lo_w) || (px_w > x_hi_w) ||
                      (py_w < y_lo_w) || (py_w > y_hi_w);

   // Shared multiply-accumulate: one limb product per cycle while the controller
   // sets mac_en, added at its limb offset.
   assign a_limb   = pick(cmd.a_src, cmd.a_idx);
   assign b_limb   = pick(cmd.b_src, {2'b00, cmd.b_idx});
   assign pp       = PAIR_W'(a_limb) * PAIR_W'(b_limb);
   assign pp_shift = cmd.a_idx + {2'b00, cmd.b_idx};
   assign pp_wide  = ACC_W'(pp) << (LIMB_W * pp_shift);
   assign acc_in   = cmd.mac_en ? ((cmd.mac_clear ? '0 : acc_ff) + pp_wide) : acc_ff;

   assign acc_pair = acc_ff[PAIR_W-1:0];
   assign lhs_wide = ACC_W'(lhs_ff) << LHS_SHIFT;

   // N is the magnitude of a difference of two products whose signs are known.
   assign p_sum_w = {1'b0, p1_ff} + {1'b0, acc_pair};
   assign p_sum   = p_sum_w[PAIR_W-1:0];
   assign p_diff  = (p1_ff >= acc_pair) ? (p1_ff - acc_pair) : (acc_pair - p1_ff);
   assign n_in    = n_add_ff ? p_sum : p_diff;

   always_comb begin
      priority if (speed_fault_ff) verdict = VIOL_SPEED;
      else if (bend_fault_ff)      verdict = VIOL_BEND;
      else if (bound_fault_ff)     verdict = VIOL_BOUND;
      else                         verdict = VIOL_NONE;
   end

   // Payload, operand, accumulator, product store and verdict registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         vxm_ff   <= req_vel_x[31] ? (~req_vel_x + 32'd1) : req_vel_x;
         vym_ff   <= req_vel_y[31] ? (~req_vel_y + 32'd1) : req_vel_y;
         last_ff  <= req_final_point;
      end
      if (cmd.prep) begin
         dxm_ff   <= dx_s[32]  ? 32'(~dx_s + 33'd1)  : dx_s[31:0];
         dym_ff   <= dy_s[32]  ? 32'(~dy_s + 33'd1)  : dy_s[31:0];
         ddxm_ff  <= ddx_s[33] ? 33'(~ddx_s + 34'd1) : ddx_s[32:0];
         ddym_ff  <= ddy_s[33] ? 33'(~ddy_s + 34'd1) : ddy_s[32:0];
         n_add_ff <= (dx_s[32] ^ ddy_s[33]) != (dy_s[32] ^ ddx_s[33]);
      end
      acc_ff <= acc_in;
      unique case (cmd.latch)
         DST_VSUM: vsum_ff <= acc_pair;
         DST_S:    s_ff    <= acc_pair;
         DST_P1:   p1_ff   <= acc_pair;
         DST_N:    n_ff    <= n_in;
         DST_LHS:  lhs_ff  <= acc_ff[QUAD_W-1:0];
         DST_SQ:   sq_ff   <= acc_ff[QUAD_W-1:0];
         DST_CUBE: cube_ff <= acc_ff[SIX_W-1:0];
         DST_KSQ:  ksq_ff  <= acc_pair;
         default: ;
      endcase
      if (cmd.commit && last_ff) begin
         feasible_ff  <= (verdict == VIOL_NONE);
         violation_ff <= verdict;
      end
   end

   // Point store, flags and result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         older_x_ff     <= '0;
         older_y_ff     <= '0;
         newer_x_ff     <= '0;
         newer_y_ff     <= '0;
         points_ff      <= '0;
         speed_fault_ff <= 1'b0;
         bend_fault_ff  <= 1'b0;
         bound_fault_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.prep && bound_hit) begin
            bound_fault_ff <= 1'b1;
         end
         if (cmd.latch == DST_SPEED && vsum_ff > acc_pair) begin
            speed_fault_ff <= 1'b1;
         end
         if (cmd.latch == DST_BEND && lhs_wide > acc_ff) begin
            bend_fault_ff <= 1'b1;
         end
         if (cmd.commit && last_ff) begin
            older_x_ff     <= '0;
            older_y_ff     <= '0;
            newer_x_ff     <= '0;
            newer_y_ff     <= '0;
            points_ff      <= '0;
            speed_fault_ff <= 1'b0;
            bend_fault_ff  <= 1'b0;
            bound_fault_ff <= 1'b0;
         end else if (cmd.commit) begin
            older_x_ff <= newer_x_ff;
            older_y_ff <= newer_y_ff;
            newer_x_ff <= pos_x_ff;
            newer_y_ff <= pos_y_ff;
            if (points_ff != 2'd3) begin
               points_ff <= points_ff + 2'd1;
            end
         end
         if (cmd.commit && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.points_ge2  = points_ff[1];
   assign status.short_step  = (s_ff <= SHORT_LIMIT);
   assign status.last_point  = last_ff;
   assign status.rsp_blocked = rsp_valid_ff && !rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_feasible  = feasible_ff;
   assign rsp_violation = violation_ff;

endmodule

FILE: rtl/trajectory_feasibility_checker.sv
// Trajectory feasibility checker, top level. Uses tfc_pkg, tfc_csr, tfc_ctrl, tfc_dpath.
// A new point is taken only once the previous one has committed. The time per point
// depends on the path: before the third point of a trajectory, on a short step, or with
// the full curvature check; it is set by the shared 33x33 multiplier, which forms every
// product limb by limb.
// Reset (synchronous, active high) clears the point store, flags and result valid bit.
module trajectory_feasibility_checker import tfc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // Point transactions
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [31:0]     req_pos_x,
   input  logic signed [31:0]     req_pos_y,
   input  logic signed [31:0]     req_vel_x,
   input  logic signed [31:0]     req_vel_y,
   input  logic                   req_final_point,
   // Verdict transactions
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_feasible,
   output logic [1:0]             rsp_violation,
   // Configuration writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // The block works on one point at a time. A point is taken in the idle
   // state, its differences to the two stored points are registered, and the
   // controller then walks the product schedule: speed squared, the limit
   // squared, and, from the third point on, the curvature terms S and N and,
   // unless the step is short, N^2, S^2, S^3 and K^2 * S^3. Each product
   // steps the multiplier through its limb pairs in turn and is followed by a
   // write-back state in which the accumulator is stored or compared.
   //
   // The verdict sits in an output register, so the next point can be taken
   // while an earlier verdict still waits for the receiver. Only a second
   // last point has to wait for that register to drain before it commits.

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   tfc_csr #(
      .FRAC_BITS (FRAC_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The controller owns the sequence; it only sees the datapath's status.
   tfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the trajectory state, the arithmetic and the result
   // register.
   tfc_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_vel_x       (req_vel_x),
      .req_vel_y       (req_vel_y),
      .req_final_point (req_final_point),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_feasible    (rsp_feasible),
      .rsp_violation   (rsp_violation)
   );

endmodule
